FILE: sv/hcb_pkg.sv
// Shared types and constants of the Huffman code builder and encoder.
`default_nettype none
package hcb_pkg;

	localparam int SYM_W   = 8;
	localparam int KIND_W  = 2;
	localparam int CODE_W  = 32;
	localparam int LEN_W   = 6;
	localparam int TOTAL_W = 40;
	localparam int STAT_W  = 2;

	localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ENCODE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

	localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_UNKNOWN  = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_TOO_LONG = 2'd2;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [SYM_W-1:0]  symbol;
	} req_t;

	typedef struct packed {
		logic [CODE_W-1:0]  code_bits;
		logic [LEN_W-1:0]   code_length;
		logic [TOTAL_W-1:0] total_bits;
		logic [STAT_W-1:0]  status;
	} rsp_t;

	typedef struct packed {
		logic             load;
		logic             clear;
		logic [SYM_W-1:0] symbol;
	} load_req_t;

	typedef struct packed {
		logic start;
		logic invalidate;
		logic clear;
	} bld_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic built;
	} bld_stat_t;

endpackage
`default_nettype wire

FILE: sv/hcb_freq_store.sv
// Symbol count memory, first-seen order memory and seen flags.
`default_nettype none
module hcb_freq_store #(
	parameter int ALPHABET_SIZE = 256,
	parameter int COUNT_BITS = 24,
	localparam int AW = $clog2(ALPHABET_SIZE)
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire hcb_pkg::load_req_t      ld,
	input  wire logic                    bld_sel,
	input  wire logic [AW-1:0]           fs_addr,
	input  wire logic [AW-1:0]           seen_sym,
	output logic      [COUNT_BITS-1:0]   freq_rd,
	output logic      [AW-1:0]           fs_rd,
	output logic      [AW:0]             distinct,
	output logic                         seen,
	output logic                         busy
);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	logic [COUNT_BITS-1:0] freq_mem [ALPHABET_SIZE];
	logic [AW-1:0]         fs_mem [ALPHABET_SIZE];
	logic [ALPHABET_SIZE-1:0] valid_q;
	logic [AW:0]           distinct_q;
	logic                  ld_s1;
	logic [AW-1:0]         sym_s1;
	logic [COUNT_BITS-1:0] freq_rd_q;
	logic [AW-1:0]         fs_rd_q;
	logic [AW-1:0]         freq_ra;
	logic [COUNT_BITS-1:0] cur;
	logic [COUNT_BITS-1:0] nxt;
	logic                  fresh;
	logic                  room;

	// builder walks the table by the symbol it just fetched from first-seen order
	assign freq_ra = bld_sel ? fs_rd_q : ld.symbol[AW-1:0];
	assign fresh   = !valid_q[sym_s1];
	assign room    = distinct_q < (AW+1)'(ALPHABET_SIZE);
	assign cur     = fresh ? '0 : freq_rd_q;
	assign nxt     = (cur == COUNT_MAX) ? cur : cur + 1'b1;

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			freq_mem[sym_s1] <= nxt;
		end
		if (ld_s1 && fresh && room) begin
			fs_mem[distinct_q[AW-1:0]] <= sym_s1;
		end
		freq_rd_q <= freq_mem[freq_ra];
		fs_rd_q   <= fs_mem[fs_addr];
		sym_s1    <= ld.symbol[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			distinct_q <= '0;
			ld_s1      <= 1'b0;
		end else begin
			ld_s1 <= ld.load;
			if (ld.clear) begin
				valid_q    <= '0;
				distinct_q <= '0;
			end else if (ld_s1) begin
				valid_q[sym_s1] <= 1'b1;
				if (fresh && room) begin
					distinct_q <= distinct_q + 1'b1;
				end
			end
		end
	end

	assign freq_rd  = freq_rd_q;
	assign fs_rd    = fs_rd_q;
	assign distinct = distinct_q;
	assign seen     = valid_q[seen_sym];
	assign busy     = ld_s1;

endmodule
`default_nettype wire

FILE: sv/hcb_tree_build.sv
// Tree build sequencer with queue, node and code memories, and the code table.
`default_nettype none
module hcb_tree_build #(
	parameter int ALPHABET_SIZE = 256,
	parameter int COUNT_BITS = 24,
	localparam int AW = $clog2(ALPHABET_SIZE)
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire hcb_pkg::bld_ctl_t            ctl,
	input  wire logic [AW:0]                  n,
	input  wire logic [COUNT_BITS-1:0]        freq_rd,
	input  wire logic [AW-1:0]                fs_rd,
	output logic      [AW-1:0]                fs_addr,
	input  wire logic [AW-1:0]                ct_addr,
	output logic      [hcb_pkg::CODE_W-1:0]   ct_code,
	output logic      [AW-1:0]                ct_len,
	output logic      [hcb_pkg::TOTAL_W-1:0]  total,
	output hcb_pkg::bld_stat_t                stat
);

	localparam int NODES = 2 * ALPHABET_SIZE - 1;
	localparam int NW = $clog2(NODES);
	localparam int WW = COUNT_BITS + AW;
	localparam int LW = AW;
	localparam int QW = NW + WW;
	localparam int CW = hcb_pkg::CODE_W;
	localparam int DW = CW + LW;
	localparam int PW = COUNT_BITS + LW;
	localparam int TW = hcb_pkg::TOTAL_W;

	localparam int STATE_W = 4;
	localparam logic [STATE_W-1:0] S_IDLE    = 4'd0;
	localparam logic [STATE_W-1:0] S_LF_RD   = 4'd1;
	localparam logic [STATE_W-1:0] S_LF_FQ   = 4'd2;
	localparam logic [STATE_W-1:0] S_LF_WR   = 4'd3;
	localparam logic [STATE_W-1:0] S_INS_CHK = 4'd4;
	localparam logic [STATE_W-1:0] S_INS_CMP = 4'd5;
	localparam logic [STATE_W-1:0] S_MG_CHK  = 4'd6;
	localparam logic [STATE_W-1:0] S_MG_RDB  = 4'd7;
	localparam logic [STATE_W-1:0] S_MG_WR   = 4'd8;
	localparam logic [STATE_W-1:0] S_AS_CHK  = 4'd9;
	localparam logic [STATE_W-1:0] S_AS_LEFT = 4'd10;
	localparam logic [STATE_W-1:0] S_AS_RGT  = 4'd11;
	localparam logic [STATE_W-1:0] S_FN_RD   = 4'd12;
	localparam logic [STATE_W-1:0] S_FN_FQ   = 4'd13;
	localparam logic [STATE_W-1:0] S_FN_MUL  = 4'd14;
	localparam logic [STATE_W-1:0] S_FN_ACC  = 4'd15;

	// memories
	logic [QW-1:0]   q_mem  [NODES];
	logic [2*NW-1:0] st_mem [NODES];
	logic [DW-1:0]   cd_mem [NODES];
	logic [DW-1:0]   ct_mem [ALPHABET_SIZE];

	logic [QW-1:0]   q_rd_q;
	logic [2*NW-1:0] st_rd_q;
	logic [DW-1:0]   cd_rd_q;
	logic [DW-1:0]   ct_rd_q;

	logic            q_we;
	logic [NW-1:0]   q_wa;
	logic [QW-1:0]   q_wd;
	logic [NW-1:0]   q_ra;
	logic            st_we;
	logic [NW-1:0]   st_ra;
	logic            cd_we;
	logic [NW-1:0]   cd_wa;
	logic [DW-1:0]   cd_wd;
	logic [NW-1:0]   cd_ra;
	logic            ct_we;

	// sequencer registers
	logic [STATE_W-1:0] state_q;
	logic               built_q;
	logic               done_q;
	logic [AW:0]        i_q;
	logic [AW:0]        mleft_q;
	logic [NW-1:0]      cnt_q;
	logic [NW-1:0]      head_q;
	logic [NW-1:0]      p_q;
	logic [NW-1:0]      lo_q;
	logic [NW-1:0]      ins_id_q;
	logic [WW-1:0]      ins_w_q;
	logic               ins_merge_q;
	logic [QW-1:0]      a_q;
	logic [NW-1:0]      right_q;
	logic [CW-1:0]      code_q;
	logic [LW-1:0]      len_q;
	logic [AW-1:0]      sym_q;
	logic [PW-1:0]      prod_q;
	logic [TW-1:0]      total_q;

	logic [WW-1:0]      q_rd_w;
	logic [NW-1:0]      q_rd_id;
	logic [WW-1:0]      a_w;
	logic [NW-1:0]      a_id;
	logic [WW-1:0]      merged_w;
	logic [CW-1:0]      cd_rd_code;
	logic [LW-1:0]      cd_rd_len;
	logic [LW-1:0]      cd_len_inc;
	logic [LW-1:0]      len_q_inc;
	logic [TW:0]        acc_sum;
	logic               ins_done;
	logic [NW-1:0]      n_node;

	assign q_rd_w     = q_rd_q[WW-1:0];
	assign q_rd_id    = q_rd_q[QW-1:WW];
	assign a_w        = a_q[WW-1:0];
	assign a_id       = a_q[QW-1:WW];
	assign merged_w   = a_w + q_rd_w;
	assign cd_rd_code = cd_rd_q[DW-1:LW];
	assign cd_rd_len  = cd_rd_q[LW-1:0];
	assign cd_len_inc = cd_rd_len + 1'b1;
	assign len_q_inc  = len_q + 1'b1;
	assign acc_sum    = {1'b0, total_q} + (TW+1)'(prod_q);
	assign n_node     = NW'(n);
	assign fs_addr    = i_q[AW-1:0];
	assign st_ra      = cnt_q - 1'b1;

	assign ins_done = ((state_q == S_INS_CHK) && !(p_q > lo_q)) ||
	                  ((state_q == S_INS_CMP) && !(q_rd_w > ins_w_q));

	always_comb begin
		q_we  = 1'b0;
		q_wa  = p_q;
		q_wd  = {ins_id_q, ins_w_q};
		q_ra  = p_q - 1'b1;
		st_we = 1'b0;
		cd_we = 1'b0;
		cd_wa = cnt_q;
		cd_wd = '0;
		cd_ra = cnt_q - 1'b1;
		ct_we = 1'b0;
		unique case (state_q)
			S_LF_WR: begin
				cd_we = 1'b1;
				cd_wa = NW'(i_q);
			end
			S_INS_CHK: begin
				q_we = !(p_q > lo_q);
			end
			S_INS_CMP: begin
				q_we = 1'b1;
				if (q_rd_w > ins_w_q) begin
					q_wd = q_rd_q;
				end
			end
			S_MG_CHK: begin
				q_ra = head_q;
			end
			S_MG_RDB: begin
				q_ra = head_q + 1'b1;
			end
			S_MG_WR: begin
				st_we = 1'b1;
				cd_we = 1'b1;
			end
			S_AS_LEFT: begin
				cd_we = 1'b1;
				cd_wa = st_rd_q[2*NW-1:NW];
				cd_wd = {cd_rd_code[CW-2:0], 1'b0, cd_len_inc};
			end
			S_AS_RGT: begin
				cd_we = 1'b1;
				cd_wa = right_q;
				cd_wd = {code_q[CW-2:0], 1'b1, len_q_inc};
			end
			S_FN_RD: begin
				cd_ra = NW'(i_q);
			end
			S_FN_MUL: begin
				ct_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_we) begin
			q_mem[q_wa] <= q_wd;
		end
		if (st_we) begin
			st_mem[cnt_q] <= {a_id, q_rd_id};
		end
		if (cd_we) begin
			cd_mem[cd_wa] <= cd_wd;
		end
		if (ct_we) begin
			ct_mem[sym_q] <= {code_q, len_q};
		end
		q_rd_q  <= q_mem[q_ra];
		st_rd_q <= st_mem[st_ra];
		cd_rd_q <= cd_mem[cd_ra];
		ct_rd_q <= ct_mem[ct_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			built_q     <= 1'b0;
			done_q      <= 1'b0;
			i_q         <= '0;
			mleft_q     <= '0;
			cnt_q       <= '0;
			head_q      <= '0;
			p_q         <= '0;
			lo_q        <= '0;
			ins_id_q    <= '0;
			ins_w_q     <= '0;
			ins_merge_q <= 1'b0;
			a_q         <= '0;
			right_q     <= '0;
			code_q      <= '0;
			len_q       <= '0;
			sym_q       <= '0;
			prod_q      <= '0;
			total_q     <= '0;
		end else begin
			done_q <= (state_q == S_FN_RD) && (i_q == n);
			unique case (state_q)
				S_IDLE: begin
					if (ctl.start) begin
						i_q     <= '0;
						total_q <= '0;
						state_q <= S_LF_RD;
					end
				end
				S_LF_RD: begin
					if (i_q == n) begin
						cnt_q   <= n_node;
						head_q  <= '0;
						mleft_q <= (n == '0) ? '0 : n - 1'b1;
						state_q <= S_MG_CHK;
					end else begin
						state_q <= S_LF_FQ;
					end
				end
				S_LF_FQ: begin
					state_q <= S_LF_WR;
				end
				S_LF_WR: begin
					ins_id_q    <= NW'(i_q);
					ins_w_q     <= WW'(freq_rd);
					p_q         <= NW'(i_q);
					lo_q        <= '0;
					ins_merge_q <= 1'b0;
					state_q     <= S_INS_CHK;
				end
				S_INS_CHK: begin
					// insertion finished: resume the leaf or merge walk
					if (ins_done) begin
						if (ins_merge_q) begin
							cnt_q   <= cnt_q + 1'b1;
							mleft_q <= mleft_q - 1'b1;
							state_q <= S_MG_CHK;
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= S_LF_RD;
						end
					end else begin
						state_q <= S_INS_CMP;
					end
				end
				S_INS_CMP: begin
					if (ins_done) begin
						if (ins_merge_q) begin
							cnt_q   <= cnt_q + 1'b1;
							mleft_q <= mleft_q - 1'b1;
							state_q <= S_MG_CHK;
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= S_LF_RD;
						end
					end else begin
						// shift the heavier entry up and keep scanning down
						p_q     <= p_q - 1'b1;
						state_q <= S_INS_CHK;
					end
				end
				S_MG_CHK: begin
					state_q <= (mleft_q == '0) ? S_AS_CHK : S_MG_RDB;
				end
				S_MG_RDB: begin
					a_q     <= q_rd_q;
					state_q <= S_MG_WR;
				end
				S_MG_WR: begin
					head_q      <= head_q + 2'd2;
					ins_id_q    <= cnt_q;
					ins_w_q     <= merged_w;
					p_q         <= cnt_q;
					lo_q        <= head_q + 2'd2;
					ins_merge_q <= 1'b1;
					state_q     <= S_INS_CHK;
				end
				S_AS_CHK: begin
					if (cnt_q == n_node) begin
						i_q     <= '0;
						state_q <= S_FN_RD;
					end else begin
						state_q <= S_AS_LEFT;
					end
				end
				S_AS_LEFT: begin
					right_q <= st_rd_q[NW-1:0];
					code_q  <= cd_rd_code;
					len_q   <= cd_rd_len;
					state_q <= S_AS_RGT;
				end
				S_AS_RGT: begin
					cnt_q   <= cnt_q - 1'b1;
					state_q <= S_AS_CHK;
				end
				S_FN_RD: begin
					if (i_q == n) begin
						built_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_FN_FQ;
					end
				end
				S_FN_FQ: begin
					sym_q   <= fs_rd;
					code_q  <= cd_rd_code;
					len_q   <= cd_rd_len;
					state_q <= S_FN_MUL;
				end
				S_FN_MUL: begin
					prod_q  <= freq_rd * len_q;
					state_q <= S_FN_ACC;
				end
				S_FN_ACC: begin
					total_q <= acc_sum[TW] ? '1 : acc_sum[TW-1:0];
					i_q     <= i_q + 1'b1;
					state_q <= S_FN_RD;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (ctl.invalidate) begin
				built_q <= 1'b0;
			end
			if (ctl.clear) begin
				total_q <= '0;
			end
		end
	end

	assign ct_code    = ct_rd_q[DW-1:LW];
	assign ct_len     = ct_rd_q[LW-1:0];
	assign total      = total_q;
	assign stat.busy  = (state_q != S_IDLE);
	assign stat.done  = done_q;
	assign stat.built = built_q;

endmodule
`default_nettype wire

FILE: sv/huffman_code_builder_encoder_unit.sv
// Top level of the static Huffman code builder and encoder.
//
// Request channel (req_valid, req_stall, req): kind load counts a byte symbol,
// kind encode asks for that symbol's code, kind clear forgets everything.
// Response channel (rsp_valid, rsp_stall, rsp): one item per encode request
// with code bits, code length, total coded size of the loaded text and status.
// A load reads the count, then writes the updated count back.
// An encode on a built tree reads the code table into its read register,
// then the response goes to the output register; no new item is taken
// while the lookup stage still holds an encode.
// The first encode after a clear or a load of an in-range symbol builds
// the tree: leaf fetch and merges, each with a stable insertion sort into
// the queue, then code assignment, then the code table and total.
// Reset clears seen flags, distinct count, built flag and total, not the
// count memory: a fresh symbol counts from zero, so no clearing pass runs.
// While the receiver stalls, the response holds in the output register and
// loads and clears go on; a further encode waits.
`default_nettype none
module huffman_code_builder_encoder_unit #(
	parameter int ALPHABET_SIZE = 256,
	parameter int MAX_CODE_BITS = 32,
	parameter int COUNT_BITS = 24
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire hcb_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output hcb_pkg::rsp_t      rsp
);

	localparam int AW = $clog2(ALPHABET_SIZE);

	logic                           accept;
	logic                           in_range;
	logic                           is_load;
	logic                           is_encode;
	logic                           is_clear;
	hcb_pkg::load_req_t             ld;
	hcb_pkg::bld_ctl_t              bld_ctl;
	hcb_pkg::bld_stat_t             bld_stat;
	logic [COUNT_BITS-1:0]          freq_rd;
	logic [AW-1:0]                  fs_rd;
	logic [AW-1:0]                  fs_addr;
	logic [AW:0]                    distinct;
	logic                           seen;
	logic                           ld_busy;
	logic [AW-1:0]                  ct_addr;
	logic [hcb_pkg::CODE_W-1:0]     ct_code;
	logic [AW-1:0]                  ct_len;
	logic [hcb_pkg::TOTAL_W-1:0]    total;

	logic                           enc_s1_q;
	logic                           enc_wait_q;
	logic [hcb_pkg::SYM_W-1:0]      enc_sym_q;
	logic                           rsp_valid_q;
	hcb_pkg::rsp_t                  rsp_q;
	hcb_pkg::rsp_t                  result;
	logic                           enc_in_range;
	logic                           too_long;
	logic                           out_free;

	// hold off new items while any earlier one is still in flight
	assign req_stall = bld_stat.busy || ld_busy || enc_s1_q || enc_wait_q;
	assign accept    = req_valid && !req_stall;
	assign in_range  = {1'b0, req.symbol} < (hcb_pkg::SYM_W+1)'(ALPHABET_SIZE);
	assign is_load   = accept && (req.kind == hcb_pkg::KIND_LOAD);
	assign is_encode = accept && (req.kind == hcb_pkg::KIND_ENCODE);
	assign is_clear  = accept && (req.kind == hcb_pkg::KIND_CLEAR);

	assign ld.load   = is_load && in_range;
	assign ld.clear  = is_clear;
	assign ld.symbol = req.symbol;

	// any change to the counts makes the current tree stale
	assign bld_ctl.start      = is_encode && !bld_stat.built;
	assign bld_ctl.invalidate = (is_load && in_range) || is_clear;
	assign bld_ctl.clear      = is_clear;

	hcb_freq_store #(
		.ALPHABET_SIZE(ALPHABET_SIZE),
		.COUNT_BITS(COUNT_BITS)
	) u_store (
		.clk(clk),
		.arst_n(arst_n),
		.ld(ld),
		.bld_sel(bld_stat.busy),
		.fs_addr(fs_addr),
		.seen_sym(enc_sym_q[AW-1:0]),
		.freq_rd(freq_rd),
		.fs_rd(fs_rd),
		.distinct(distinct),
		.seen(seen),
		.busy(ld_busy)
	);

	// code table read: fresh symbol on accept, held symbol while waiting
	assign ct_addr = (enc_wait_q || enc_s1_q) ? enc_sym_q[AW-1:0] : req.symbol[AW-1:0];

	hcb_tree_build #(
		.ALPHABET_SIZE(ALPHABET_SIZE),
		.COUNT_BITS(COUNT_BITS)
	) u_build (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(bld_ctl),
		.n(distinct),
		.freq_rd(freq_rd),
		.fs_rd(fs_rd),
		.fs_addr(fs_addr),
		.ct_addr(ct_addr),
		.ct_code(ct_code),
		.ct_len(ct_len),
		.total(total),
		.stat(bld_stat)
	);

	assign enc_in_range = {1'b0, enc_sym_q} < (hcb_pkg::SYM_W+1)'(ALPHABET_SIZE);
	assign too_long     = (32'(ct_len) > 32'(MAX_CODE_BITS)) ||
	                      (32'(ct_len) > 32'(hcb_pkg::CODE_W));

	always_comb begin
		result.total_bits  = total;
		result.code_bits   = '0;
		result.code_length = '0;
		if (!(enc_in_range && seen)) begin
			result.status = hcb_pkg::STATUS_UNKNOWN;
		end else if (too_long) begin
			result.status = hcb_pkg::STATUS_TOO_LONG;
		end else begin
			result.status      = hcb_pkg::STATUS_OK;
			result.code_bits   = ct_code;
			result.code_length = hcb_pkg::LEN_W'(ct_len);
		end
	end

	assign out_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk) begin
		if (is_encode) begin
			enc_sym_q <= req.symbol;
		end
		if (enc_s1_q && out_free) begin
			rsp_q <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enc_s1_q    <= 1'b0;
			enc_wait_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (is_encode) begin
				enc_s1_q   <= bld_stat.built;
				enc_wait_q <= !bld_stat.built;
			end else if (bld_stat.done) begin
				enc_wait_q <= 1'b0;
				enc_s1_q   <= 1'b1;
			end else if (enc_s1_q && out_free) begin
				enc_s1_q <= 1'b0;
			end
			// drop the response once taken, refill from the lookup stage
			if (enc_s1_q && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_no_accept_in_build: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !bld_stat.busy)
		else $error("item accepted while the tree build runs");

	a_done_only_on_request: assert property (@(posedge clk) disable iff (!arst_n)
		bld_stat.done |-> enc_wait_q)
		else $error("tree build finished with no encode waiting");

	a_lookup_on_built_tree: assert property (@(posedge clk) disable iff (!arst_n)
		enc_s1_q |-> bld_stat.built)
		else $error("code lookup on a stale tree");

endmodule
`default_nettype wire
